/* src/ptrm_pkg.sv */
// Shared types, constants and control store for the port traffic rate monitor.
package ptrm_pkg;

    localparam int PORTS_DEFAULT   = 64;
    localparam int HISTORY_DEFAULT = 30;

    localparam int DELTA_W  = 32;
    localparam int SUM_W    = 37;
    localparam int WIN_W    = 5;
    localparam int PORT_W   = 6;
    localparam int KIND_W   = 2;
    localparam int S_DATA_W = 264;
    localparam int M_DATA_W = 112;
    localparam int UPC_W    = 4;

    localparam logic [WIN_W-1:0] SHORT_WINDOW_RST = 5'd6;
    localparam logic [WIN_W-1:0] LONG_WINDOW_RST  = 5'd30;

    // configuration register indexes
    localparam logic CFG_SHORT_WINDOW = 1'b0;
    localparam logic CFG_LONG_WINDOW  = 1'b1;

    // input command codes
    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // counter kinds in output order
    localparam logic [KIND_W-1:0] KIND_RX_PACKETS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RX_BYTES   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TX_PACKETS = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TX_BYTES   = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_ADVANCE,
        OP_MARK,
        OP_CLEAR,
        OP_READ_LAST,
        OP_DELTA,
        OP_SUM,
        OP_EMIT,
        OP_NEXT_KIND
    } uop_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_SKIP,
        C_SEEN,
        C_CLR_MORE,
        C_SUM_BUSY,
        C_OUT_BUSY,
        C_KIND_LAST
    } ucond_t;

    typedef struct packed {
        uop_t             op;
        ucond_t           cond;
        logic [UPC_W-1:0] target;
    } uword_t;

    localparam logic [UPC_W-1:0] UPC_FETCH     = 4'd0;
    localparam logic [UPC_W-1:0] UPC_DISPATCH  = 4'd1;
    localparam logic [UPC_W-1:0] UPC_MARK      = 4'd2;
    localparam logic [UPC_W-1:0] UPC_CLEAR     = 4'd3;
    localparam logic [UPC_W-1:0] UPC_READ_LAST = 4'd4;
    localparam logic [UPC_W-1:0] UPC_DELTA     = 4'd5;
    localparam logic [UPC_W-1:0] UPC_SUM       = 4'd6;
    localparam logic [UPC_W-1:0] UPC_EMIT      = 4'd7;
    localparam logic [UPC_W-1:0] UPC_NEXT_KIND = 4'd8;
    localparam logic [UPC_W-1:0] UPC_LOOP      = 4'd9;

    // control store: on a true condition jump to target, else fall through
    function automatic uword_t ucode_rom(input logic [UPC_W-1:0] upc);
        uword_t w;
        case (upc)
            UPC_FETCH:     w = '{OP_ACCEPT,    C_NO_ITEM,   UPC_FETCH};
            UPC_DISPATCH:  w = '{OP_ADVANCE,   C_SKIP,      UPC_FETCH};
            UPC_MARK:      w = '{OP_MARK,      C_SEEN,      UPC_READ_LAST};
            UPC_CLEAR:     w = '{OP_CLEAR,     C_CLR_MORE,  UPC_CLEAR};
            UPC_READ_LAST: w = '{OP_READ_LAST, C_NEVER,     UPC_FETCH};
            UPC_DELTA:     w = '{OP_DELTA,     C_NEVER,     UPC_FETCH};
            UPC_SUM:       w = '{OP_SUM,       C_SUM_BUSY,  UPC_SUM};
            UPC_EMIT:      w = '{OP_EMIT,      C_OUT_BUSY,  UPC_EMIT};
            UPC_NEXT_KIND: w = '{OP_NEXT_KIND, C_KIND_LAST, UPC_FETCH};
            UPC_LOOP:      w = '{OP_NONE,      C_ALWAYS,    UPC_READ_LAST};
            default:       w = '{OP_NONE,      C_ALWAYS,    UPC_FETCH};
        endcase
        return w;
    endfunction

endpackage

/* src/port_traffic_rate_monitor.sv */
// Port traffic rate monitor: microcoded per-port delta history and window sums.
//
// Each sample request gives four results (rx packets, rx bytes, tx packets,
// tx bytes; tlast on the fourth). For a sample, every window sum walks the
// port's history ring one entry per cycle, over the larger of the two windows
// capped at HISTORY, through the single read port of the history memory. The
// first sample of a port first zeroes that port's rings. An advance request
// gives no result, nor does a sample for a port at or above PORTS, which is
// dropped. One request is worked at a time; the output register lets the next
// request in while a result waits.
module port_traffic_rate_monitor #(
    parameter int PORTS   = ptrm_pkg::PORTS_DEFAULT,
    parameter int HISTORY = ptrm_pkg::HISTORY_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // cfg_addr: 0 short_window, 1 long_window
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [ptrm_pkg::WIN_W-1:0]    cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // port_index[5:0], rx_bytes[69:6], rx_packets[133:70], tx_bytes[197:134],
    // tx_packets[261:198], zero pad
    input  logic [ptrm_pkg::S_DATA_W-1:0] s_tdata,
    // command
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // port_out[5:0], current_delta[37:6], short_sum[74:38], long_sum[111:75]
    output logic [ptrm_pkg::M_DATA_W-1:0] m_tdata,
    // counter_kind
    output logic [ptrm_pkg::KIND_W-1:0]   m_tuser,
    output logic                          m_tlast
);
    import ptrm_pkg::*;

    localparam int PIW     = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int SLW     = $clog2(PORTS * 4);
    localparam int HDEPTH  = PORTS * 4 * HISTORY;
    localparam int HAW     = $clog2(HDEPTH);
    localparam int PW      = $clog2(HISTORY);
    localparam int CW      = $clog2(HISTORY + 1);
    localparam int CCW     = $clog2(4 * HISTORY);
    localparam logic [CCW-1:0] CLR_LAST = CCW'(4 * HISTORY - 1);
    localparam logic [PW-1:0]  POS_LAST = PW'(HISTORY - 1);

    // memories
    logic [DELTA_W-1:0] hist_mem [HDEPTH];
    logic [DELTA_W-1:0] last_mem [PORTS*4];

    // sequencer
    logic [UPC_W-1:0] upc_reg, upc_next;
    uword_t           uw;
    logic             cond_true;

    // request registers
    logic                    cmd_reg;
    logic [PORT_W-1:0]       port_reg;
    logic [3:0][DELTA_W-1:0] samp_reg;

    // datapath state
    logic [PORTS-1:0]   port_seen_reg;
    logic [PW-1:0]      pos_reg;
    logic [WIN_W-1:0]   short_window_reg, long_window_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic               first_reg;
    logic [HAW-1:0]     clr_addr_reg;
    logic [CCW-1:0]     clr_cnt_reg;
    logic [HAW-1:0]     base_reg;
    logic [PW-1:0]      ptr_reg;
    logic [CW-1:0]      iss_cnt_reg, acc_cnt_reg;
    logic               rd_valid_reg;
    logic [SUM_W-1:0]   short_acc_reg, long_acc_reg;
    logic [DELTA_W-1:0] delta_reg;
    logic [DELTA_W-1:0] last_rd_reg;
    logic [DELTA_W-1:0] hist_rd_reg;

    // output register
    logic               m_tvalid_reg;
    logic [PORT_W-1:0]  out_port_reg;
    logic [KIND_W-1:0]  out_kind_reg;
    logic [DELTA_W-1:0] out_delta_reg;
    logic [SUM_W-1:0]   out_short_reg, out_long_reg;
    logic               out_last_reg;

    // derived values
    logic [PIW-1:0]     port_idx;
    logic [SLW-1:0]     slot;
    logic [HAW-1:0]     port_base;
    logic [HAW-1:0]     slot_base;
    logic [CW-1:0]      short_sat, long_sat, n_win;
    logic               out_busy;
    logic               issue;
    logic [DELTA_W-1:0] delta_val;
    logic [SUM_W-1:0]   hist_ext;
    logic               accept;

    assign port_idx  = PIW'(port_reg);
    assign slot      = SLW'({port_reg, kind_reg});
    assign port_base = HAW'(SLW'({port_reg, 2'b00})) * HAW'(HISTORY);
    assign slot_base = HAW'(slot) * HAW'(HISTORY);
    assign short_sat = (32'(short_window_reg) > HISTORY) ? CW'(HISTORY)
                                                         : CW'(short_window_reg);
    assign long_sat  = (32'(long_window_reg) > HISTORY) ? CW'(HISTORY)
                                                        : CW'(long_window_reg);
    assign n_win     = (short_sat > long_sat) ? short_sat : long_sat;
    assign out_busy  = m_tvalid_reg && !m_tready;
    assign issue     = (uw.op == OP_SUM) && (iss_cnt_reg < n_win);
    assign delta_val = first_reg ? '0 : samp_reg[kind_reg] - last_rd_reg;
    assign hist_ext  = SUM_W'(signed'(hist_rd_reg));
    assign accept    = s_tready && s_tvalid;
    assign s_tready  = aresetn && (uw.op == OP_ACCEPT);

    always_comb begin
        uw = ucode_rom(upc_reg);
        case (uw.cond)
            C_NEVER:     cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_NO_ITEM:   cond_true = !s_tvalid;
            C_SKIP:      cond_true = (cmd_reg == CMD_ADVANCE) || (32'(port_reg) >= PORTS);
            C_SEEN:      cond_true = port_seen_reg[port_idx];
            C_CLR_MORE:  cond_true = (clr_cnt_reg != CLR_LAST);
            C_SUM_BUSY:  cond_true = (iss_cnt_reg < n_win) || rd_valid_reg;
            C_OUT_BUSY:  cond_true = out_busy;
            C_KIND_LAST: cond_true = (kind_reg == KIND_TX_BYTES);
            default:     cond_true = 1'b0;
        endcase
        upc_next = cond_true ? uw.target : upc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg          <= UPC_FETCH;
            port_seen_reg    <= '0;
            pos_reg          <= '0;
            short_window_reg <= SHORT_WINDOW_RST;
            long_window_reg  <= LONG_WINDOW_RST;
            m_tvalid_reg     <= 1'b0;
            rd_valid_reg     <= 1'b0;
        end else begin
            upc_reg <= upc_next;
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_SHORT_WINDOW) begin
                    short_window_reg <= cfg_wr_data;
                end
                if (cfg_addr == CFG_LONG_WINDOW) begin
                    long_window_reg <= cfg_wr_data;
                end
            end
            if (uw.op == OP_ADVANCE && cmd_reg == CMD_ADVANCE) begin
                pos_reg <= (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
            end
            if (uw.op == OP_MARK) begin
                port_seen_reg[port_idx] <= 1'b1;
            end
            rd_valid_reg <= issue;
            if (uw.op == OP_EMIT && !out_busy) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg     <= s_tuser;
            port_reg    <= s_tdata[5:0];
            samp_reg[0] <= s_tdata[101:70];   // rx packets
            samp_reg[1] <= s_tdata[37:6];     // rx bytes
            samp_reg[2] <= s_tdata[229:198];  // tx packets
            samp_reg[3] <= s_tdata[165:134];  // tx bytes
        end
        case (uw.op)
            OP_MARK: begin
                first_reg    <= !port_seen_reg[port_idx];
                clr_addr_reg <= port_base;
                clr_cnt_reg  <= '0;
                kind_reg     <= KIND_RX_PACKETS;
            end
            OP_CLEAR: begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                clr_cnt_reg  <= clr_cnt_reg + 1'b1;
            end
            OP_READ_LAST: begin
                base_reg      <= slot_base;
                ptr_reg       <= pos_reg;
                iss_cnt_reg   <= '0;
                acc_cnt_reg   <= '0;
                short_acc_reg <= '0;
                long_acc_reg  <= '0;
            end
            OP_DELTA: begin
                delta_reg <= delta_val;
            end
            OP_SUM: begin
                if (issue) begin
                    ptr_reg     <= (ptr_reg == '0) ? POS_LAST : ptr_reg - 1'b1;
                    iss_cnt_reg <= iss_cnt_reg + 1'b1;
                end
                if (rd_valid_reg) begin
                    acc_cnt_reg <= acc_cnt_reg + 1'b1;
                    if (acc_cnt_reg < short_sat) begin
                        short_acc_reg <= short_acc_reg + hist_ext;
                    end
                    if (acc_cnt_reg < long_sat) begin
                        long_acc_reg <= long_acc_reg + hist_ext;
                    end
                end
            end
            OP_NEXT_KIND: begin
                kind_reg <= kind_reg + 1'b1;
            end
            default: begin
            end
        endcase
        if (uw.op == OP_EMIT && !out_busy) begin
            out_port_reg  <= port_reg;
            out_kind_reg  <= kind_reg;
            out_delta_reg <= delta_reg;
            out_short_reg <= short_acc_reg;
            out_long_reg  <= long_acc_reg;
            out_last_reg  <= (kind_reg == KIND_TX_BYTES);
        end
    end

    // history ring memory: zeroed per port on first sample, one read port
    always_ff @(posedge aclk) begin
        if (uw.op == OP_CLEAR) begin
            hist_mem[clr_addr_reg] <= '0;
        end else if (uw.op == OP_DELTA) begin
            hist_mem[base_reg + HAW'(ptr_reg)] <= delta_val;
        end
        if (issue) begin
            hist_rd_reg <= hist_mem[base_reg + HAW'(ptr_reg)];
        end
    end

    // last count memory, low 32 bits are all the delta needs
    always_ff @(posedge aclk) begin
        if (uw.op == OP_DELTA) begin
            last_mem[slot] <= samp_reg[kind_reg];
        end
        if (uw.op == OP_READ_LAST) begin
            last_rd_reg <= last_mem[slot];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_long_reg, out_short_reg, out_delta_reg, out_port_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule
